/* rtl/awf_pkg.sv */
package awf_pkg;

	// Fixed datapath widths, sized for a window of radius 15 (961 pixels)
	localparam int CW    = 11;	// coordinate and window bound
	localparam int NW    = 10;	// pixel count
	localparam int SW    = 20;	// sum of channel sums
	localparam int QW    = 30;	// sum of squared channel sums
	localparam int VW    = 40;	// n*Q - S*S
	localparam int LW    = 56;	// variance and noise terms scaled by 2^16
	localparam int REMW  = 64;	// dividend and remainder
	localparam int QTW   = 9;	// quotient bits, magnitude never exceeds 255
	localparam int DSW   = REMW + QTW;
	localparam int OFFW  = 10;	// signed correction

	// Register indexes
	localparam logic [1:0] REG_WIDTH  = 2'd0;
	localparam logic [1:0] REG_HEIGHT = 2'd1;
	localparam logic [1:0] REG_RADIUS = 2'd2;
	localparam logic [1:0] REG_NOISE  = 2'd3;

	// Reset values
	localparam logic [9:0]  RST_WIDTH  = 10'd512;
	localparam logic [9:0]  RST_HEIGHT = 10'd512;
	localparam logic [2:0]  RST_RADIUS = 3'd1;
	localparam logic [15:0] RST_NOISE  = 16'd0;

	// Controller steps, also the controller state codes
	localparam logic [3:0] OP_IDLE  = 4'd0;
	localparam logic [3:0] OP_SETUP = 4'd1;
	localparam logic [3:0] OP_WALK  = 4'd2;
	localparam logic [3:0] OP_DRAIN = 4'd3;
	localparam logic [3:0] OP_M1    = 4'd4;
	localparam logic [3:0] OP_M2    = 4'd5;
	localparam logic [3:0] OP_M3    = 4'd6;
	localparam logic [3:0] OP_M4    = 4'd7;
	localparam logic [3:0] OP_M5    = 4'd8;
	localparam logic [3:0] OP_M6    = 4'd9;
	localparam logic [3:0] OP_M7    = 4'd10;
	localparam logic [3:0] OP_M8    = 4'd11;
	localparam logic [3:0] OP_DLOAD = 4'd12;
	localparam logic [3:0] OP_DIV   = 4'd13;
	localparam logic [3:0] OP_ROUND = 4'd14;
	localparam logic [3:0] OP_OUT   = 4'd15;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;
	localparam int DEF_MAX_RADIUS = 7;

	typedef struct packed {
		logic       take;
		logic [3:0] op;
	} cmd_t;

	typedef struct packed {
		logic in_image;
		logic walk_last;
		logic pipe_empty;
		logic div_last;
		logic out_full;
	} status_t;

endpackage

/* rtl/awf_store.sv */
module awf_store #(
	parameter int DEPTH = awf_pkg::DEF_MAX_WIDTH * awf_pkg::DEF_MAX_HEIGHT,
	parameter int AW    = 18
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];
	logic [23:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* rtl/awf_ctrl.sv */
module awf_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	input  logic             in_mode,
	input  awf_pkg::status_t status,
	output awf_pkg::cmd_t    cmd
);
	import awf_pkg::*;

	logic [3:0] state_q;
	logic [3:0] state_d;

	always_comb begin
		state_d = state_q;
		case (state_q)
			OP_IDLE: begin
				if (in_valid && in_mode) begin
					state_d = OP_SETUP;
				end
			end
			OP_SETUP: state_d = status.in_image ? OP_WALK : OP_IDLE;
			OP_WALK: begin
				if (status.walk_last) begin
					state_d = OP_DRAIN;
				end
			end
			OP_DRAIN: begin
				if (status.pipe_empty) begin
					state_d = OP_M1;
				end
			end
			OP_M1:    state_d = OP_M2;
			OP_M2:    state_d = OP_M3;
			OP_M3:    state_d = OP_M4;
			OP_M4:    state_d = OP_M5;
			OP_M5:    state_d = OP_M6;
			OP_M6:    state_d = OP_M7;
			OP_M7:    state_d = OP_M8;
			OP_M8:    state_d = OP_DLOAD;
			OP_DLOAD: state_d = OP_DIV;
			OP_DIV: begin
				if (status.div_last) begin
					state_d = OP_ROUND;
				end
			end
			OP_ROUND: state_d = OP_OUT;
			OP_OUT: begin
				if (!status.out_full) begin
					state_d = OP_IDLE;
				end
			end
			default: state_d = OP_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= OP_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign cmd.take = (state_q == OP_IDLE);
	assign cmd.op   = state_q;

endmodule

/* rtl/awf_datapath.sv */
module awf_datapath #(
	parameter int MAX_WIDTH  = awf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = awf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = awf_pkg::DEF_MAX_RADIUS
) (
	input  logic             clk,
	input  logic             arst_n,
	input  awf_pkg::cmd_t    cmd,
	input  logic             cfg_we,
	input  logic [1:0]       cfg_index,
	input  logic [15:0]      cfg_data,
	input  logic             in_valid,
	input  logic [47:0]      in_data,
	input  logic             in_mode,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [39:0]      out_data,
	output awf_pkg::status_t status
);
	import awf_pkg::*;

	localparam int Depth = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (Depth > 1) ? $clog2(Depth) : 1;

	function automatic logic [AW-1:0] addr_of(input logic [CW-1:0] y, input logic [CW-1:0] x);
		return AW'(int'(y) * MAX_WIDTH + int'(x));
	endfunction

	function automatic logic [7:0] clamp8(input logic [7:0] c, input logic signed [OFFW-1:0] off);
		logic signed [OFFW:0] t;
		t = signed'({3'b000, c}) + OFFW'(off);
		if (t < 0) begin
			return 8'd0;
		end else if (t > 255) begin
			return 8'd255;
		end
		return t[7:0];
	endfunction

	// configuration
	logic [9:0]  width_q, height_q;
	logic [2:0]  radius_q;
	logic [15:0] noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= RST_WIDTH;
			height_q <= RST_HEIGHT;
			radius_q <= RST_RADIUS;
			noise_q  <= RST_NOISE;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_WIDTH:  width_q  <= cfg_data[9:0];
				REG_HEIGHT: height_q <= cfg_data[9:0];
				REG_RADIUS: radius_q <= cfg_data[2:0];
				REG_NOISE:  noise_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	logic [CW-1:0] w_eff, h_eff, r_eff;
	assign w_eff = (int'(width_q) > MAX_WIDTH) ? CW'(MAX_WIDTH) : CW'(width_q);
	assign h_eff = (int'(height_q) > MAX_HEIGHT) ? CW'(MAX_HEIGHT) : CW'(height_q);
	assign r_eff = (int'(radius_q) > MAX_RADIUS) ? CW'(MAX_RADIUS) : CW'(radius_q);

	// input fields
	logic [8:0] in_col, in_row;
	assign in_col = in_data[8:0];
	assign in_row = in_data[17:9];

	logic accept;
	assign accept = cmd.take && in_valid;

	logic [8:0] col_q, row_q;
	always_ff @(posedge clk) begin
		if (accept && in_mode) begin
			col_q <= in_col;
			row_q <= in_row;
		end
	end

	// frame store
	logic          st_we, st_re;
	logic [AW-1:0] st_waddr, st_raddr;
	logic [23:0]   st_rdata;

	assign st_we = accept && !in_mode && (int'(in_col) < MAX_WIDTH)
		&& (int'(in_row) < MAX_HEIGHT);
	assign st_waddr = addr_of(CW'(in_row), CW'(in_col));

	awf_store #(.DEPTH(Depth), .AW(AW)) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (in_data[41:18]),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	// window bounds
	logic [CW-1:0] colx, rowx;
	logic [CW-1:0] x0_d, x1_d, y0_d, y1_d;
	logic [CW-1:0] x0_q, x1_q, y1_q, xi_q, yi_q;
	logic          in_image;

	assign colx = CW'(col_q);
	assign rowx = CW'(row_q);
	assign in_image = (colx < w_eff) && (rowx < h_eff);
	assign x0_d = (colx > r_eff) ? colx - r_eff : '0;
	assign y0_d = (rowx > r_eff) ? rowx - r_eff : '0;
	assign x1_d = (colx + r_eff < w_eff) ? colx + r_eff + CW'(1) : w_eff;
	assign y1_d = (rowx + r_eff < h_eff) ? rowx + r_eff + CW'(1) : h_eff;

	logic x_end, y_end;
	assign x_end = (xi_q + CW'(1) == x1_q);
	assign y_end = (yi_q + CW'(1) == y1_q);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_SETUP: begin
				x0_q <= x0_d;
				x1_q <= x1_d;
				y1_q <= y1_d;
				xi_q <= x0_d;
				yi_q <= y0_d;
			end
			OP_WALK: begin
				if (x_end) begin
					xi_q <= x0_q;
					yi_q <= yi_q + CW'(1);
				end else begin
					xi_q <= xi_q + CW'(1);
				end
			end
			default: ;
		endcase
	end

	assign st_re = (cmd.op == OP_WALK) || ((cmd.op == OP_SETUP) && in_image);
	assign st_raddr = (cmd.op == OP_WALK) ? addr_of(yi_q, xi_q) : addr_of(rowx, colx);

	// read pipeline: store data, channel sum, accumulate
	logic        rd_walk_s1, rd_own_s1, acc_vld_s2;
	logic [9:0]  s_s2;
	logic [23:0] own_px_q;
	logic [SW-1:0] sum_q;
	logic [QW-1:0] sq_q;
	logic [NW-1:0] n_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_walk_s1 <= 1'b0;
			rd_own_s1  <= 1'b0;
			acc_vld_s2 <= 1'b0;
		end else begin
			rd_walk_s1 <= (cmd.op == OP_WALK);
			rd_own_s1  <= (cmd.op == OP_SETUP) && in_image;
			acc_vld_s2 <= rd_walk_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_own_s1) begin
			own_px_q <= st_rdata;
		end
		s_s2 <= 10'(st_rdata[7:0]) + 10'(st_rdata[15:8]) + 10'(st_rdata[23:16]);
		if (cmd.op == OP_SETUP) begin
			sum_q <= '0;
			sq_q  <= '0;
			n_q   <= '0;
		end else if (acc_vld_s2) begin
			sum_q <= sum_q + SW'(s_s2);
			sq_q  <= sq_q + QW'(s_s2) * QW'(s_s2);
			n_q   <= n_q + NW'(1);
		end
	end

	logic [9:0] own_s;
	assign own_s = 10'(own_px_q[7:0]) + 10'(own_px_q[15:8]) + 10'(own_px_q[23:16]);

	// statistics and comparison terms
	logic [VW-1:0]        t1_q, t2_q, v_q;
	logic [SW-1:0]        t3_q, p_q;
	logic signed [SW:0]   d_q;
	logic [31:0]          nl2_q, t7_q;
	logic [SW-1:0]        nn_q;
	logic [51:0]          t6_q;
	logic [NW+1:0]        n3_q;
	logic [LW-1:0]        lhs_q, rhs_q;
	logic [63:0]          t8_q;
	logic                 neg_q, lt_q, vz_q;

	// shared multiplier
	logic [31:0] mul_a, mul_b;
	logic [63:0] prod;

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			OP_M1: begin
				mul_a = 32'(sq_q);
				mul_b = 32'(n_q);
			end
			OP_M2: begin
				mul_a = 32'(sum_q);
				mul_b = 32'(sum_q);
			end
			OP_M3: begin
				mul_a = 32'(n_q);
				mul_b = 32'(own_s);
			end
			OP_M4: begin
				mul_a = 32'(noise_q);
				mul_b = 32'(noise_q);
			end
			OP_M5: begin
				mul_a = 32'(n_q);
				mul_b = 32'(n_q);
			end
			default: ;
		endcase
		if (cmd.op == OP_M6) begin
			mul_a = 32'(nn_q);
			mul_b = nl2_q;
		end else if (cmd.op == OP_M7) begin
			mul_a = 32'(n3_q);
			mul_b = 32'(p_q);
		end else if (cmd.op == OP_M8) begin
			mul_a = t7_q;
			mul_b = nl2_q;
		end
	end

	assign prod = 64'(mul_a) * 64'(mul_b);

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_M1: t1_q <= prod[VW-1:0];
			OP_M2: t2_q <= prod[VW-1:0];
			OP_M3: begin
				v_q  <= t1_q - t2_q;
				t3_q <= prod[SW-1:0];
			end
			OP_M4: begin
				d_q   <= signed'({1'b0, sum_q}) - signed'({1'b0, t3_q});
				nl2_q <= prod[31:0];
			end
			OP_M5: begin
				neg_q <= d_q[SW];
				p_q   <= d_q[SW] ? SW'(-d_q) : SW'(d_q);
				nn_q  <= prod[SW-1:0];
			end
			OP_M6: begin
				t6_q <= prod[51:0];
				n3_q <= (NW+2)'(n_q) + (NW+2)'({n_q, 1'b0});
			end
			OP_M7: begin
				rhs_q <= (LW'(t6_q) << 3) + LW'(t6_q);
				lhs_q <= {v_q, 16'h0000};
				t7_q  <= prod[31:0];
			end
			OP_M8: begin
				lt_q <= lhs_q < rhs_q;
				vz_q <= (v_q == '0);
				t8_q <= prod;
			end
			default: ;
		endcase
	end

	// restoring divider, one quotient bit per cycle
	logic [REMW-1:0] rem_q, den_q;
	logic [DSW-1:0]  den_sh_q;
	logic [QTW-1:0]  quo_q;
	logic [3:0]      bit_q;
	logic            div_ge;

	assign div_ge = DSW'(rem_q) >= den_sh_q;

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_DLOAD: begin
				if (lt_q) begin
					rem_q    <= REMW'(p_q);
					den_q    <= REMW'(n3_q);
					den_sh_q <= DSW'(n3_q) << (QTW - 1);
				end else if (vz_q) begin
					rem_q    <= '0;
					den_q    <= REMW'(1);
					den_sh_q <= DSW'(1) << (QTW - 1);
				end else begin
					rem_q    <= t8_q;
					den_q    <= REMW'(lhs_q);
					den_sh_q <= DSW'(lhs_q) << (QTW - 1);
				end
				quo_q <= '0;
				bit_q <= 4'(QTW - 1);
			end
			OP_DIV: begin
				if (div_ge) begin
					rem_q <= rem_q - REMW'(den_sh_q);
				end
				quo_q    <= {quo_q[QTW-2:0], div_ge};
				den_sh_q <= den_sh_q >> 1;
				bit_q    <= bit_q - 4'd1;
			end
			default: ;
		endcase
	end

	// round half up
	logic [REMW:0]          twice_r, den_x;
	logic signed [OFFW-1:0] qs, off_q;

	assign twice_r = {rem_q, 1'b0};
	assign den_x   = {1'b0, den_q};
	assign qs      = signed'(OFFW'(quo_q));

	always_ff @(posedge clk) begin
		if (cmd.op == OP_ROUND) begin
			if (!neg_q) begin
				off_q <= qs + ((twice_r >= den_x) ? OFFW'(1) : OFFW'(0));
			end else if (rem_q != '0) begin
				off_q <= -qs - OFFW'(1) + ((twice_r <= den_x) ? OFFW'(1) : OFFW'(0));
			end else begin
				off_q <= -qs;
			end
		end
	end

	// output register
	logic       out_valid_q, out_load;
	logic [7:0] c0, c1, c2;
	logic [39:0] out_data_q;

	assign c0 = clamp8(own_px_q[7:0], off_q);
	assign c1 = clamp8(own_px_q[15:8], off_q);
	assign c2 = clamp8(own_px_q[23:16], off_q);
	assign out_load = (cmd.op == OP_OUT) && !status.out_full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {6'd0, 10'(c0) + 10'(c1) + 10'(c2), c2, c1, c0};
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	assign status.in_image   = in_image;
	assign status.walk_last  = x_end && y_end;
	assign status.pipe_empty = !rd_walk_s1 && !acc_vld_s2;
	assign status.div_last   = (bit_q == 4'd0);
	assign status.out_full   = out_valid_q && !out_ready;

endmodule

/* rtl/adaptive_wiener_filter.sv */
// Channel   Dir  Payload
// s_axis    in   tdata {blue, green, red, row, column}, tuser mode
// m_axis    out  tdata {sum, blue, green, red}
// cfg       in   cfg_we / cfg_index / cfg_data, one register per write
//
// A load transfer writes the frame store and leaves the sequencer idle.
// A filter transfer walks the clipped window (n pixels), one store read per
// cycle, then takes eight steps on the shared 32x32 multiplier, nine quotient
// bits from the restoring divider, then rounding.
// The result waits in the output register; the next item is taken meanwhile.
// Reset (arst_n) clears control, config and valid flags, not the frame store.
module adaptive_wiener_filter #(
	parameter int MAX_WIDTH  = awf_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = awf_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_RADIUS = awf_pkg::DEF_MAX_RADIUS
) (
	input  logic        clk,
	input  logic        arst_n,
	// config write port
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data,
	// input stream
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [47:0] s_axis_tdata,	// column[8:0], row[17:9], in_red[25:18],
						// in_green[33:26], in_blue[41:34]
	input  logic [0:0]  s_axis_tuser,	// mode[0]: 0 load, 1 filter
	// result stream
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [39:0] m_axis_tdata	// out_red[7:0], out_green[15:8],
						// out_blue[23:16], out_sum[33:24]
);
	import awf_pkg::*;

	cmd_t    cmd;
	status_t status;

	// sequencer: idle, setup, window walk, drain, math steps, divide, round, out
	awf_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_mode  (s_axis_tuser[0]),
		.status   (status),
		.cmd      (cmd)
	);

	awf_datapath #(
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.MAX_RADIUS (MAX_RADIUS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (s_axis_tvalid),
		.in_data   (s_axis_tdata),
		.in_mode   (s_axis_tuser[0]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_data  (m_axis_tdata),
		.status    (status)
	);

	// input is taken only while the sequencer sits idle
	assign s_axis_tready = cmd.take;

endmodule

/* rtl/awf_checker.sv */
module awf_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [0:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [39:0] m_axis_tdata
);

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// sum field matches the channels
	a_sum: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tdata[33:24] == ({2'b00, m_axis_tdata[7:0]}
			+ {2'b00, m_axis_tdata[15:8]} + {2'b00, m_axis_tdata[23:16]}))
		else $error("out_sum mismatch");

	// a filter transfer occupies the block
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && s_axis_tuser[0] |=> !s_axis_tready)
		else $error("ready after filter transfer");

	// a load never produces a result
	a_load_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !s_axis_tuser[0] && !m_axis_tvalid
		|=> !m_axis_tvalid)
		else $error("result after load");

endmodule

bind adaptive_wiener_filter awf_checker u_awf_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tuser  (s_axis_tuser),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata)
);
